>>> hw/rtl/pse_pkg.sv
package pse_pkg;

    localparam int VALUE_W = 32;
    localparam int OP_W    = 3;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_ADD = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL = 3'd2;
    localparam logic [OP_W-1:0] OP_DIV = 3'd3;
    localparam logic [OP_W-1:0] OP_POW = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DIVZERO   = 2'd3;

    typedef struct packed {
        logic                  mode;
        logic [VALUE_W-1:0]    value;
        logic [OP_W-1:0]       op;
        logic                  last;
    } token_t;

endpackage

>>> hw/rtl/pse_token_if.sv
interface pse_token_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [31:0] value;
    logic [2:0]  op;
    logic        last;

    modport source (output valid, mode, value, op, last, input ready);
    modport sink (input valid, mode, value, op, last, output ready);
endinterface

>>> hw/rtl/pse_result_if.sv
interface pse_result_if #(
    parameter int DEPTH_W = 6
);
    logic               valid;
    logic               ready;
    logic [31:0]        top_value;
    logic [DEPTH_W-1:0] stack_depth;
    logic [1:0]         status;
    logic               final_res;

    modport source (output valid, top_value, stack_depth, status, final_res, input ready);
    modport sink (input valid, top_value, stack_depth, status, final_res, output ready);
endinterface

>>> hw/rtl/pse_ram.sv
module pse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> hw/rtl/pse_alu.sv
// Multi-cycle arithmetic unit: add/sub/mul in one pass, divide restoring
// one bit per cycle, power by square-and-multiply one exponent bit at a
// time, with the two multiplies in alternating cycles.
module pse_alu
    import pse_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [OP_W-1:0]    op,
    input  logic [VALUE_W-1:0] a,
    input  logic [VALUE_W-1:0] b,
    output logic               done,
    output logic [VALUE_W-1:0] result
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_POW  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic [VALUE_W-1:0] base_reg, base_next;
    logic [VALUE_W-1:0] ex_reg, ex_next;
    logic [VALUE_W-1:0] rem_reg, rem_next;
    logic               neg_reg, neg_next;
    logic               phase_reg, phase_next;
    logic [VALUE_W-1:0] res_reg, res_next;
    logic [VALUE_W-1:0] mag_a, mag_b;
    logic [VALUE_W:0]   trial;
    logic [VALUE_W-1:0] rem_shift;
    logic [VALUE_W-1:0] mul_x, mul_y, mul_p;

    assign mag_a = a[VALUE_W-1] ? VALUE_W'(0) - a : a;
    assign mag_b = b[VALUE_W-1] ? VALUE_W'(0) - b : b;
    assign rem_shift = {rem_reg[VALUE_W-2:0], ex_reg[VALUE_W-1]};
    assign trial = {1'b0, rem_shift} - {1'b0, base_reg};

    // One shared multiplier.
    always_comb
    begin
        if (state_reg == S_POW)
        begin
            mul_x = phase_reg ? base_reg : acc_reg;
            mul_y = base_reg;
        end
        else
        begin
            mul_x = a;
            mul_y = b;
        end
    end
    assign mul_p = VALUE_W'(mul_x * mul_y);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        base_next  = base_reg;
        ex_next    = ex_reg;
        rem_next   = rem_reg;
        neg_next   = neg_reg;
        phase_next = phase_reg;
        res_next   = res_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DONE;
                    case (op)
                        OP_ADD: res_next = a + b;
                        OP_SUB: res_next = a - b;
                        OP_MUL: res_next = mul_p;
                        OP_DIV:
                        begin
                            if (b == '0)
                            begin
                                res_next = '0;
                            end
                            else
                            begin
                                base_next  = mag_b;
                                ex_next    = mag_a;
                                rem_next   = '0;
                                neg_next   = a[VALUE_W-1] ^ b[VALUE_W-1];
                                cnt_next   = 6'd32;
                                state_next = S_DIV;
                            end
                        end
                        OP_POW:
                        begin
                            if (b[VALUE_W-1])
                            begin
                                if (a == VALUE_W'(1))
                                    res_next = VALUE_W'(1);
                                else if (a == '1)
                                    res_next = b[0] ? '1 : VALUE_W'(1);
                                else
                                    res_next = '0;
                            end
                            else
                            begin
                                acc_next   = VALUE_W'(1);
                                base_next  = a;
                                ex_next    = b;
                                phase_next = 1'b0;
                                state_next = S_POW;
                            end
                        end
                        default: res_next = '0;
                    endcase
                end
            end
            S_DIV:
            begin
                // ex holds the dividend being shifted out, collecting quotient bits.
                if (!trial[VALUE_W])
                    rem_next = trial[VALUE_W-1:0];
                else
                    rem_next = rem_shift;
                ex_next  = {ex_reg[VALUE_W-2:0], ~trial[VALUE_W]};
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    res_next   = neg_reg ? VALUE_W'(0) - ex_next : ex_next;
                    state_next = S_DONE;
                end
            end
            S_POW:
            begin
                if (ex_reg == '0)
                begin
                    res_next   = acc_reg;
                    state_next = S_DONE;
                end
                else if (!phase_reg)
                begin
                    if (ex_reg[0])
                        acc_next = mul_p;
                    phase_next = 1'b1;
                end
                else
                begin
                    base_next  = mul_p;
                    ex_next    = ex_reg >> 1;
                    phase_next = 1'b0;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        acc_reg   <= acc_next;
        base_reg  <= base_next;
        ex_reg    <= ex_next;
        rem_reg   <= rem_next;
        neg_reg   <= neg_next;
        phase_reg <= phase_next;
        res_reg   <= res_next;
    end

    assign done   = (state_reg == S_DONE);
    assign result = res_reg;

endmodule

>>> hw/rtl/postfix_stack_evaluator_unit.sv
// Channel  | Dir | Fields
// tok      | in  | mode, value, op, last
// res      | out | top_value, stack_depth, status, final_res
//
// A push passes through accept, top-of-stack read and emit. An operator
// passes through accept, two stack reads through the single read port of
// the stack RAM, the arithmetic unit, top read and emit.
// One word is processed at a time; a result waits in the output register
// while the next word is already taken, and the next result holds in the
// emit state until that register is free. rst_n empties the stack at once.
module postfix_stack_evaluator_unit
    import pse_pkg::*;
#(
    parameter int STACK_DEPTH = 32
) (
    input logic          clk,
    input logic          rst_n,
    pse_token_if.sink    tok,
    pse_result_if.source res
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int PW = $clog2(STACK_DEPTH + 1);
    localparam int DW = $bits(res.stack_depth);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RDB   = 3'd1;
    localparam logic [2:0] S_RDA   = 3'd2;
    localparam logic [2:0] S_ALU   = 3'd3;
    localparam logic [2:0] S_WAIT  = 3'd4;
    localparam logic [2:0] S_TOP   = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [PW-1:0]       sp_reg, sp_next;
    token_t              tok_reg, tok_next;
    logic [VALUE_W-1:0]  a_reg, a_next;
    logic [VALUE_W-1:0]  b_reg, b_next;
    logic [VALUE_W-1:0]  top_reg, top_next;
    logic                top_known_reg, top_known_next;
    logic [STATUS_W-1:0] st_reg, st_next;
    logic                ovalid_reg, ovalid_next;
    logic [VALUE_W-1:0]  o_top_reg, o_top_next;
    logic [PW-1:0]       o_depth_reg, o_depth_next;
    logic [STATUS_W-1:0] o_st_reg, o_st_next;
    logic                o_fin_reg, o_fin_next;

    logic                wr_en;
    logic [AW-1:0]       wr_addr, rd_addr;
    logic [VALUE_W-1:0]  wr_data, rd_data;
    logic                alu_start, alu_done;
    logic [VALUE_W-1:0]  alu_result;
    logic                out_free;
    logic [PW-1:0]       sp_dec;

    assign out_free = !ovalid_reg || res.ready;
    assign tok.ready = (state_reg == S_IDLE);
    assign sp_dec = sp_reg - PW'(1);

    pse_ram #(.WIDTH(VALUE_W), .DEPTH(STACK_DEPTH)) u_stack (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    pse_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .start (alu_start),
        .op    (tok_reg.op),
        .a     (a_reg),
        .b     (b_reg),
        .done  (alu_done),
        .result(alu_result)
    );

    always_comb
    begin
        state_next     = state_reg;
        sp_next        = sp_reg;
        tok_next       = tok_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        top_next       = top_reg;
        top_known_next = top_known_reg;
        st_next        = st_reg;
        ovalid_next    = ovalid_reg && !res.ready;
        o_top_next     = o_top_reg;
        o_depth_next   = o_depth_reg;
        o_st_next      = o_st_reg;
        o_fin_next     = o_fin_reg;
        wr_en          = 1'b0;
        wr_addr        = sp_reg[AW-1:0];
        wr_data        = '0;
        rd_addr        = sp_dec[AW-1:0];
        alu_start      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (tok.valid)
                begin
                    tok_next = '{mode: tok.mode, value: tok.value, op: tok.op, last: tok.last};
                    st_next  = ST_OK;
                    if (!tok.mode)
                    begin
                        if (sp_reg >= PW'(STACK_DEPTH))
                        begin
                            st_next        = ST_OVERFLOW;
                            top_known_next = 1'b0;
                        end
                        else
                        begin
                            wr_en          = 1'b1;
                            wr_data        = tok.value;
                            sp_next        = sp_reg + PW'(1);
                            top_next       = tok.value;
                            top_known_next = 1'b1;
                        end
                        state_next = S_TOP;
                    end
                    else
                    begin
                        state_next = S_RDB;
                    end
                end
            end
            S_RDB:
            begin
                // Read of b was issued in IDLE at sp-1; now issue a.
                state_next = S_RDA;
                if (sp_reg == '0)
                begin
                    st_next = ST_UNDERFLOW;
                    b_next  = '0;
                end
                else
                begin
                    sp_next = sp_dec;
                    b_next  = rd_data;
                end
                rd_addr = sp_next[AW-1:0] - AW'(1);
            end
            S_RDA:
            begin
                if (sp_reg == '0)
                begin
                    st_next = ST_UNDERFLOW;
                    a_next  = '0;
                end
                else
                begin
                    sp_next = sp_dec;
                    a_next  = rd_data;
                end
                state_next = S_ALU;
            end
            S_ALU:
            begin
                alu_start = 1'b1;
                if (tok_reg.op == OP_DIV && b_reg == '0 && st_reg == ST_OK)
                    st_next = ST_DIVZERO;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (alu_done)
                begin
                    wr_data = alu_result;
                    if (sp_reg >= PW'(STACK_DEPTH))
                    begin
                        if (st_reg == ST_OK)
                            st_next = ST_OVERFLOW;
                        top_known_next = 1'b0;
                    end
                    else
                    begin
                        wr_en          = 1'b1;
                        sp_next        = sp_reg + PW'(1);
                        top_next       = alu_result;
                        top_known_next = 1'b1;
                    end
                    state_next = S_TOP;
                end
            end
            S_TOP:
            begin
                // Top word is re-read from the RAM when the last write was dropped.
                rd_addr    = sp_dec[AW-1:0];
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    o_fin_next  = tok_reg.last;
                    o_st_next   = st_reg;
                    if (sp_reg == '0)
                        o_top_next = '0;
                    else if (top_known_reg)
                        o_top_next = top_reg;
                    else
                        o_top_next = rd_data;
                    if (tok_reg.last)
                    begin
                        if (sp_reg == '0)
                            o_st_next = ST_UNDERFLOW;
                        sp_next = '0;
                    end
                    o_depth_next = tok_reg.last ? '0 : sp_reg;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            sp_reg     <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sp_reg     <= sp_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg       <= tok_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        top_reg       <= top_next;
        top_known_reg <= top_known_next;
        st_reg        <= st_next;
        o_top_reg     <= o_top_next;
        o_depth_reg   <= o_depth_next;
        o_st_reg      <= o_st_next;
        o_fin_reg     <= o_fin_next;
    end

    assign res.valid       = ovalid_reg;
    assign res.top_value   = o_top_reg;
    assign res.stack_depth = DW'(o_depth_reg);
    assign res.status      = o_st_reg;
    assign res.final_res   = o_fin_reg;

endmodule
